[rtl/ttip_pkg.sv]
package ttip_pkg;

    localparam int unsigned OFFSET_MAX_DEF = 32'd65535;
    localparam int          BASE_W         = 5;
    localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;
    localparam logic [BASE_W-1:0] BASE_HEX   = 5'd16;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [3:0] HEX_TEN  = 4'd10;

    typedef enum logic [1:0] {
        PH_DONE   = 2'd0,
        PH_LEAD   = 2'd1,
        PH_DIGITS = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic   negative;
        logic   emit;
        logic   count;
    } step_ctl_t;

endpackage

[rtl/text_to_integer_parser_top.sv]
// channel  | ports       | tdata (low bit up)                    | tuser
// ---------+-------------+---------------------------------------+---------
// input    | s_t*        | [7:0] char_code                       | [0] first
// result   | m_t*        | [63:0] parsed_value, [79:64] end_offset | none
// config   | cfg_wr_*    | [4:0] number_base                     | none
//
// One character per cycle unless a stopping character waits: an input register, then
// the radix multiply-add and the phase update into the state and result registers.
// The accumulator feedback loop (64 by 5 bit multiply-add) sets the cycle.
// Synchronous active-low reset: phase done, base 10, both stages empty.
// A stalled result beat holds; characters that yield no result keep flowing,
// a stopping character waits in the input register until the result slot frees.
module text_to_integer_parser_top #(
    parameter int unsigned OFFSET_MAX = ttip_pkg::OFFSET_MAX_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] char_code
    input  logic [0:0]                  s_tuser,   // [0] first
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [79:0]                 m_tdata,   // [63:0] parsed_value, [79:64] end_offset
    input  logic                        cfg_wr_en,
    input  logic [ttip_pkg::BASE_W-1:0] cfg_wr_data
);
    import ttip_pkg::*;

    localparam int CNT_W = $clog2(64'(OFFSET_MAX) + 64'd1);

    logic              in_valid_reg;
    logic [7:0]        in_char_reg;
    logic              in_first_reg;
    logic [BASE_W-1:0] base_reg;
    phase_t            phase_reg;
    logic              neg_reg;
    logic [63:0]       acc_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              m_valid_reg;
    logic [63:0]       m_value_reg;
    logic [15:0]       m_offset_reg;

    step_ctl_t         ctl;
    logic [63:0]       acc_next;
    logic [CNT_W-1:0]  cnt_next;
    logic [63:0]       value_next;
    logic [31:0]       cnt_ext;
    logic              out_free;
    logic              advance;

    ttip_step #(
        .OFFSET_MAX(OFFSET_MAX)
    ) u_step (
        .char_code   (in_char_reg),
        .first       (in_first_reg),
        .number_base (base_reg),
        .phase_cur   (phase_reg),
        .negative_cur(neg_reg),
        .acc_cur     (acc_reg),
        .cnt_cur     (cnt_reg),
        .ctl         (ctl),
        .acc_next    (acc_next),
        .cnt_next    (cnt_next),
        .parsed_value(value_next)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!ctl.emit || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign cnt_ext  = 32'(cnt_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_RESET;
        end else if (cfg_wr_en) begin
            base_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg  <= s_tdata;
            in_first_reg <= s_tuser[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DONE;
            neg_reg   <= 1'b0;
            acc_reg   <= 64'd0;
            cnt_reg   <= '0;
        end else if (advance) begin
            phase_reg <= ctl.phase;
            neg_reg   <= ctl.negative;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && ctl.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // on a stop beat the count is unchanged, so cnt_next is the consumed count
    always_ff @(posedge aclk) begin
        if (advance && ctl.emit) begin
            m_value_reg  <= value_next;
            m_offset_reg <= cnt_ext[15:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_offset_reg, m_value_reg};

    a_cnt_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(OFFSET_MAX))
        else $error("consumed count beyond saturation limit");

    a_reset_done: assert property (@(posedge aclk)
        !aresetn |=> phase_reg == PH_DONE && !m_valid_reg && !in_valid_reg)
        else $error("reset did not clear parse state");

    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && ctl.emit |=> m_tvalid && phase_reg == PH_DONE)
        else $error("stop beat did not produce a result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |-> !(advance && ctl.emit))
        else $error("pending result overwritten");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && phase_reg == PH_DONE && !in_first_reg |=> !m_valid_reg || $past(m_valid_reg))
        else $error("result from a finished parse");

endmodule

[rtl/ttip_step.sv]
module ttip_step #(
    parameter int unsigned OFFSET_MAX = ttip_pkg::OFFSET_MAX_DEF,
    localparam int CNT_W = $clog2(64'(OFFSET_MAX) + 64'd1)
) (
    input  logic [7:0]                  char_code,
    input  logic                        first,
    input  logic [ttip_pkg::BASE_W-1:0] number_base,
    input  ttip_pkg::phase_t            phase_cur,
    input  logic                        negative_cur,
    input  logic [63:0]                 acc_cur,
    input  logic [CNT_W-1:0]            cnt_cur,
    output ttip_pkg::step_ctl_t         ctl,
    output logic [63:0]                 acc_next,
    output logic [CNT_W-1:0]            cnt_next,
    output logic [63:0]                 parsed_value
);
    import ttip_pkg::*;

    phase_t           ph_eff;
    logic             neg_eff;
    logic [63:0]      acc_eff;
    logic [CNT_W-1:0] cnt_eff;
    logic             hex_mode;
    logic             is_space;
    logic             is_minus;
    logic             is_digit;
    logic             is_hexl;
    logic             is_hexu;
    logic             is_x;
    logic             is_nul;
    logic [3:0]       digit;
    logic [63:0]      mac;
    logic             take_digit;
    phase_t           phase_nx;
    logic             neg_nx;
    logic             emit_nx;
    logic             count_nx;

    // start-of-string flag clears the parse before this beat is looked at
    assign ph_eff  = first ? PH_LEAD : phase_cur;
    assign neg_eff = first ? 1'b0 : negative_cur;
    assign acc_eff = first ? 64'd0 : acc_cur;
    assign cnt_eff = first ? '0 : cnt_cur;

    assign hex_mode = (number_base == BASE_HEX);
    assign is_space = (char_code == CH_SPACE);
    assign is_minus = (char_code == CH_MINUS);
    assign is_nul   = (char_code == CH_NUL);
    assign is_digit = char_code inside {[CH_0:CH_9]};
    assign is_hexu  = hex_mode && (char_code inside {[CH_UA:CH_UF]});
    assign is_hexl  = hex_mode && (char_code inside {[CH_LA:CH_LF]});
    assign is_x     = hex_mode && (char_code == CH_UX || char_code == CH_LX);

    always_comb begin
        if (is_digit) begin
            digit = 4'(char_code - CH_0);
        end else if (is_hexu) begin
            digit = 4'(char_code - CH_UA) + HEX_TEN;
        end else begin
            digit = 4'(char_code - CH_LA) + HEX_TEN;
        end
    end

    assign mac = acc_eff * 64'(number_base) + 64'(digit);

    // next phase
    always_comb begin
        phase_nx = ph_eff;
        case (ph_eff)
            PH_DONE: phase_nx = PH_DONE;
            PH_LEAD: begin
                if (is_space) begin
                    phase_nx = PH_LEAD;
                end else if (is_minus) begin
                    phase_nx = PH_DIGITS;
                end else if (is_nul || !(is_x || is_digit || is_hexu || is_hexl)) begin
                    phase_nx = PH_DONE;
                end else begin
                    phase_nx = PH_DIGITS;
                end
            end
            PH_DIGITS: begin
                if (is_nul || !(is_x || is_digit || is_hexu || is_hexl)) begin
                    phase_nx = PH_DONE;
                end
            end
            default: phase_nx = PH_DONE;
        endcase
    end

    // data and result
    always_comb begin
        neg_nx     = neg_eff;
        emit_nx    = 1'b0;
        count_nx   = 1'b0;
        take_digit = 1'b0;
        case (ph_eff)
            PH_DONE: ;
            PH_LEAD: begin
                if (is_space) begin
                    count_nx = 1'b1;
                end else if (is_minus) begin
                    neg_nx   = 1'b1;
                    count_nx = 1'b1;
                end else if (is_nul) begin
                    emit_nx = 1'b1;
                end else if (is_x) begin
                    count_nx = 1'b1;
                end else if (is_digit || is_hexu || is_hexl) begin
                    count_nx   = 1'b1;
                    take_digit = 1'b1;
                end else begin
                    emit_nx = 1'b1;
                end
            end
            PH_DIGITS: begin
                if (is_nul) begin
                    emit_nx = 1'b1;
                end else if (is_x) begin
                    count_nx = 1'b1;
                end else if (is_digit || is_hexu || is_hexl) begin
                    count_nx   = 1'b1;
                    take_digit = 1'b1;
                end else begin
                    emit_nx = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign ctl = '{phase: phase_nx, negative: neg_nx, emit: emit_nx, count: count_nx};

    assign acc_next = take_digit ? mac : acc_eff;
    assign cnt_next = (count_nx && cnt_eff != CNT_W'(OFFSET_MAX)) ? cnt_eff + 1'b1 : cnt_eff;
    assign parsed_value = neg_eff ? (64'd0 - acc_eff) : acc_eff;

endmodule

[verif/tb_text_to_integer_parser_top.sv]
`timescale 1ns / 100ps

module tb_text_to_integer_parser_top;
    import ttip_pkg::*;

    typedef struct packed {
        logic [15:0] offset;
        logic [63:0] value;
    } parse_result_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;   // [7:0] char_code
    logic [0:0]          s_tuser;   // [0] first
    logic                m_tvalid;
    logic                m_tready;
    logic [79:0]         m_tdata;   // [63:0] parsed_value, [79:64] end_offset
    logic                cfg_wr_en;
    logic [BASE_W-1:0]   cfg_wr_data;

    text_to_integer_parser_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // parser state as the block should hold it
    logic [BASE_W-1:0] base_now;
    phase_t            phase_now;
    logic              minus_seen;
    logic [63:0]       acc_now;
    int unsigned       count_now;

    parse_result_t     results_due[$];
    parse_result_t     due;
    int                errors;
    int                live_chars;
    bit                tx_gaps;
    bit                rx_gaps;
    bit                hold_req;

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic bump_count();
        if (count_now < OFFSET_MAX_DEF) begin
            count_now++;
        end
    endtask

    task automatic post_result();
        parse_result_t r;
        r.value  = minus_seen ? (64'd0 - acc_now) : acc_now;
        r.offset = count_now[15:0];
        results_due.push_back(r);
        phase_now = PH_DONE;
    endtask

    task automatic parse_char(input logic [7:0] c, input bit f);
        if (f) begin
            phase_now  = PH_LEAD;
            minus_seen = 1'b0;
            acc_now    = '0;
            count_now  = 0;
        end
        if (phase_now == PH_DONE) begin
            return;
        end
        live_chars++;
        if (phase_now == PH_LEAD) begin
            if (c == CH_SPACE) begin
                bump_count();
                return;
            end
            phase_now = PH_DIGITS;
            if (c == CH_MINUS) begin
                minus_seen = 1'b1;
                bump_count();
                return;
            end
        end
        if (c == CH_NUL) begin
            post_result();
        end else if (base_now == BASE_HEX && (c == CH_UX || c == CH_LX)) begin
            bump_count();
        end else if (c >= CH_0 && c <= CH_9) begin
            acc_now = acc_now * 64'(base_now) + 64'(c - CH_0);
            bump_count();
        end else if (base_now == BASE_HEX && c >= CH_UA && c <= CH_UF) begin
            acc_now = acc_now * 64'(base_now) + 64'(HEX_TEN) + 64'(c - CH_UA);
            bump_count();
        end else if (base_now == BASE_HEX && c >= CH_LA && c <= CH_LF) begin
            acc_now = acc_now * 64'(base_now) + 64'(HEX_TEN) + 64'(c - CH_LA);
            bump_count();
        end else begin
            post_result();
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected beat, value %0d offset %0d", $realtime,
                         $signed(m_tdata[63:0]), m_tdata[79:64]);
                errors++;
            end else begin
                due = results_due.pop_front();
                if (m_tdata[63:0] !== due.value) begin
                    $display("%0t: parsed_value expected %0d actual %0d", $realtime,
                             $signed(due.value), $signed(m_tdata[63:0]));
                    errors++;
                end
                if (m_tdata[79:64] !== due.offset) begin
                    $display("%0t: end_offset expected %0d actual %0d", $realtime,
                             due.offset, m_tdata[79:64]);
                    errors++;
                end
            end
        end
    end

    initial begin
        m_tready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_req = 1'b0;
            end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input bit f);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= f;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        parse_char(c, f);
    endtask

    task automatic send_text(input string s, input bit f);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], f && i == 0);
        end
    endtask

    task automatic drain_all();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (results_due.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        if (results_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $realtime, results_due.size());
            errors++;
            results_due.delete();
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [BASE_W-1:0] b);
        drain_all();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= b;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        base_now = b;
    endtask

    function automatic logic [7:0] pick_digit(input bit hex);
        int r;
        r = $urandom_range(0, hex ? 22 : 9);
        if (r < 10) begin
            return CH_0 + 8'(r);
        end else if (r < 16) begin
            return CH_UA + 8'(r - 10);
        end else if (r < 22) begin
            return CH_LA + 8'(r - 16);
        end
        return $urandom_range(0, 1) ? CH_UX : CH_LX;
    endfunction

    task automatic send_random_string();
        logic [7:0] text[$];
        int         kind;
        int         n;
        kind = $urandom_range(0, 9);
        if (kind >= 8) begin
            // noise, with or without a fresh start
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                send_char(8'($urandom_range(0, 255)), kind == 9 && i == 0);
            end
            return;
        end
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 40) : $urandom_range(0, 3);
        repeat (n) text.push_back(CH_SPACE);
        if ($urandom_range(0, 2) == 0) begin
            text.push_back(CH_MINUS);
        end
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 30) : $urandom_range(0, 8);
        repeat (n) text.push_back(pick_digit(base_now == BASE_HEX));
        case ($urandom_range(0, 5))
            0, 1, 2: text.push_back(CH_NUL);
            3:       text.push_back(CH_SPACE);
            4:       text.push_back(CH_MINUS);
            default: text.push_back(8'($urandom_range(0, 255)));
        endcase
        repeat ($urandom_range(0, 2)) text.push_back(8'($urandom_range(0, 255)));
        foreach (text[i]) begin
            send_char(text[i], i == 0);
        end
    endtask

    task automatic test_directed();
        // ignored before any start
        send_text("3", 1'b0);
        send_char(CH_NUL, 1'b0);
        // sign with no digits
        send_text(" -", 1'b1);
        send_char(CH_NUL, 1'b0);
        // space after digits, minus after digits, space after sign
        send_text("-19 ", 1'b1);
        send_text("7-x", 1'b1);
        send_text(" - ", 1'b1);
        // high bytes and the neighbours of the digit range
        send_char(8'hFF, 1'b1);
        send_char(8'h80, 1'b1);
        send_text(":", 1'b1);
        send_text("/", 1'b1);
        cfg_write(BASE_HEX);
        send_text("0xfAg", 1'b1);
        send_text("XaFx", 1'b1);
        send_char(CH_NUL, 1'b0);
        // digit not below the base
        cfg_write(5'd2);
        send_text("92", 1'b1);
        send_char(CH_NUL, 1'b0);
        cfg_write(5'd0);
        send_text("57a", 1'b1);
        cfg_write(5'd31);
        send_text("1x", 1'b1);
        drain_all();
    endtask

    task automatic test_output_stall();
        cfg_write(BASE_RESET);
        tx_gaps  = 1'b0;
        hold_req = 1'b1;
        repeat (30) begin
            send_random_string();
        end
        tx_gaps = 1'b1;
        drain_all();
    endtask

    task automatic test_long_string();
        cfg_write(BASE_RESET);
        send_char(CH_SPACE, 1'b1);
        repeat (300) send_char(CH_0, 1'b0);
        send_text("5", 1'b0);
        send_char(CH_NUL, 1'b0);
        drain_all();
    endtask

    task automatic test_random_strings();
        logic [BASE_W-1:0] base_list[10];
        int                goal;
        base_list = '{5'd10, 5'd16, 5'd2, 5'd8, 5'd0, 5'd1, 5'd31, 5'd17, 5'd16, 5'd10};
        base_list[7] = 5'($urandom_range(3, 31));
        for (int k = 0; k < 10; k++) begin
            if (k == 9) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            cfg_write(base_list[k]);
            goal = live_chars + 70;
            while (live_chars < goal) begin
                send_random_string();
            end
        end
        drain_all();
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        errors      = 0;
        live_chars  = 0;
        tx_gaps     = 1'b1;
        rx_gaps     = 1'b1;
        hold_req    = 1'b0;
        base_now    = BASE_RESET;
        phase_now   = PH_DONE;
        minus_seen  = 1'b0;
        acc_now     = '0;
        count_now   = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_output_stall();
        test_long_string();
        test_random_strings();

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
